// ===== src/pca_pkg.sv =====
// Shared types and constants of the PID controller with integral clamp.
`timescale 1ns / 1ps

package pca_pkg;

  // Field and register widths.
  localparam int GainW   = 31;
  localparam int DataW   = 32;
  localparam int DtW     = 32;
  localparam int MulAW   = 32;
  localparam int MulBW   = 33;
  localparam int ProdW   = 64;
  localparam int DiffW   = 33;
  localparam int SumW    = 52;
  localparam int CfgIdxW = 2;

  // Derivative divider: 49 quotient bits, one per cycle.
  localparam int QuoW     = 49;
  localparam int DivSteps = 49;
  localparam int DivCntW  = 6;
  localparam int DivHiW   = ProdW - (QuoW - 8);

  // One microsecond is a little over 16 raw units of the Q8.24 time step.
  localparam logic [DtW-1:0] DtThreshold = 32'd16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegKp    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKi    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKd    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLimit = 2'd3;

  // Gains and clamp as seen by the datapath.
  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
    logic [GainW-1:0] limit;
  } cfg_t;

endpackage

// ===== src/pca_mul.sv =====
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module pca_mul (
  input  logic                       clk_i,
  input  logic [pca_pkg::MulAW-1:0]  a_i,
  input  logic [pca_pkg::MulBW-1:0]  b_i,
  output logic [pca_pkg::ProdW-1:0]  prod_o
);

  logic [pca_pkg::MulAW+pca_pkg::MulBW-1:0] full;
  logic [pca_pkg::ProdW-1:0]                prod_q;

  // Every product used here fits in 64 bits.
  assign full = {{pca_pkg::MulBW{1'b0}}, a_i} * {{pca_pkg::MulAW{1'b0}}, b_i};

  // Product register.
  always_ff @(posedge clk_i) begin
    prod_q <= full[pca_pkg::ProdW-1:0];
  end

  assign prod_o = prod_q;

endmodule

// ===== src/pca_div.sv =====
// Bit-serial restoring divider for the derivative term, with an overflow cap.
`timescale 1ns / 1ps

module pca_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pca_pkg::ProdW-1:0] num_i,
  input  logic [pca_pkg::DtW-1:0]   den_i,
  output logic                      done_o,
  output logic [pca_pkg::QuoW-1:0]  quo_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [pca_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [pca_pkg::DtW-1:0]     rem_q, rem_d;
  logic [pca_pkg::DtW-1:0]     den_q, den_d;
  logic [pca_pkg::QuoW-1:0]    sh_q, sh_d;
  logic [pca_pkg::DtW+1:0]     trial;
  logic                        ge;
  logic [pca_pkg::DtW-1:0]     hi;
  logic                        ovf;

  // The quotient (num * 256 / den) overflows 49 bits when the top bits of num reach den.
  assign hi  = {{(pca_pkg::DtW-pca_pkg::DivHiW){1'b0}},
                num_i[pca_pkg::ProdW-1:pca_pkg::QuoW-8]};
  assign ovf = (hi >= den_i);

  // One trial subtraction per cycle.
  assign trial = {1'b0, rem_q, sh_q[pca_pkg::QuoW-1]} - {2'b00, den_q};
  assign ge    = ~trial[pca_pkg::DtW+1];

  // Step control and data path.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    sh_d   = sh_q;
    if (start_i) begin
      den_d = den_i;
      cnt_d = '0;
      if (ovf) begin
        sh_d   = pca_pkg::QuoW'(1) << (pca_pkg::QuoW - 1);
        done_d = 1'b1;
      end else begin
        rem_d  = hi;
        sh_d   = {num_i[pca_pkg::QuoW-9:0], 8'h00};
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? trial[pca_pkg::DtW-1:0] : {rem_q[pca_pkg::DtW-2:0], sh_q[pca_pkg::QuoW-1]};
      sh_d  = {sh_q[pca_pkg::QuoW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pca_pkg::DivCntW'(pca_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

// ===== src/pca_core.sv =====
// Sequencer and state of the PID controller around the shared multiplier and the divider.
`timescale 1ns / 1ps

module pca_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pca_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pca_pkg::DataW-1:0] err_i,
  input  logic [pca_pkg::DataW-1:0] meas_i,
  input  logic [pca_pkg::DtW-1:0]   dt_i,
  input  logic                      on_meas_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output logic [pca_pkg::DataW-1:0] res_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SProp   = 3'd1;
  localparam logic [2:0] SInc    = 3'd2;
  localparam logic [2:0] SClamp  = 3'd3;
  localparam logic [2:0] SInt    = 3'd4;
  localparam logic [2:0] SDstart = 3'd5;
  localparam logic [2:0] SDiv    = 3'd6;
  localparam logic [2:0] SDone   = 3'd7;

  logic [2:0]                       state_q, state_d;
  logic signed [pca_pkg::DataW-1:0] err_q, err_d;
  logic [pca_pkg::DtW-1:0]          dt_q, dt_d;
  logic signed [pca_pkg::DiffW-1:0] diff_q, diff_d;
  logic signed [pca_pkg::DataW-1:0] last_err_q, last_err_d;
  logic signed [pca_pkg::DataW-1:0] last_meas_q, last_meas_d;
  logic signed [pca_pkg::DataW-1:0] isum_q, isum_d;
  logic signed [pca_pkg::SumW-1:0]  sum_q, sum_d;
  logic [pca_pkg::ProdW-1:0]        q_q, q_d;

  logic [pca_pkg::MulAW-1:0]        mul_a;
  logic [pca_pkg::MulBW-1:0]        mul_b;
  logic [pca_pkg::ProdW-1:0]        prod;
  logic                             div_start;
  logic                             div_done;
  logic [pca_pkg::QuoW-1:0]         quo;

  logic [pca_pkg::DataW-1:0]        err_mag;
  logic [pca_pkg::DiffW-1:0]        diff_mag;
  logic [pca_pkg::DataW-1:0]        isum_mag;
  logic signed [pca_pkg::SumW-1:0]  term48;
  logic signed [pca_pkg::SumW-1:0]  quo_ext;
  logic signed [41:0]               inc;
  logic signed [41:0]               acc;
  logic signed [41:0]               lim_ext;
  logic signed [pca_pkg::DiffW-1:0] diff_new;
  logic signed [pca_pkg::SumW-1:0]  sat_hi;
  logic signed [pca_pkg::SumW-1:0]  sat_lo;

  // Magnitudes fed to the unsigned multiplier.
  assign err_mag  = err_q[pca_pkg::DataW-1] ? (32'd0 - err_q) : err_q;
  assign diff_mag = diff_q[pca_pkg::DiffW-1] ? (33'd0 - diff_q) : diff_q;
  assign isum_mag = isum_q[pca_pkg::DataW-1] ? (32'd0 - isum_q) : isum_q;

  // Operand selection: each product is consumed in the state after the one that selects its operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      SProp: begin
        mul_a = {1'b0, cfg_i.kp};
        mul_b = {1'b0, err_mag};
      end
      SInc: begin
        mul_a = dt_q;
        mul_b = {1'b0, err_mag};
      end
      SClamp: begin
        mul_a = {1'b0, cfg_i.kd};
        mul_b = diff_mag;
      end
      SInt: begin
        mul_a = {1'b0, cfg_i.ki};
        mul_b = {1'b0, isum_mag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pca_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (q_q),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Gain products truncated to Q16.16, and the integral increment.
  assign term48  = $signed({{(pca_pkg::SumW-48){1'b0}}, prod[pca_pkg::ProdW-1:16]});
  assign quo_ext = $signed({{(pca_pkg::SumW-pca_pkg::QuoW){1'b0}}, quo});
  assign inc     = err_q[pca_pkg::DataW-1] ? -$signed({2'b00, prod[pca_pkg::ProdW-1:24]})
                                           :  $signed({2'b00, prod[pca_pkg::ProdW-1:24]});
  assign acc     = $signed({{10{isum_q[pca_pkg::DataW-1]}}, isum_q}) + inc;
  assign lim_ext = $signed({11'd0, cfg_i.limit});

  // Difference for the derivative, taken against the stored previous values.
  assign diff_new = on_meas_i
      ? ($signed({last_meas_q[pca_pkg::DataW-1], last_meas_q})
         - $signed({meas_i[pca_pkg::DataW-1], meas_i}))
      : ($signed({err_i[pca_pkg::DataW-1], err_i})
         - $signed({last_err_q[pca_pkg::DataW-1], last_err_q}));

  // Output saturation bounds.
  assign sat_hi = $signed({{(pca_pkg::SumW-31){1'b0}}, {31{1'b1}}});
  assign sat_lo = $signed({{(pca_pkg::SumW-31){1'b1}}, {31{1'b0}}});

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    dt_d        = dt_q;
    diff_d      = diff_q;
    last_err_d  = last_err_q;
    last_meas_d = last_meas_q;
    isum_d      = isum_q;
    sum_d       = sum_q;
    q_d         = q_q;
    div_start   = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          err_d       = err_i;
          dt_d        = dt_i;
          diff_d      = diff_new;
          last_err_d  = err_i;
          last_meas_d = meas_i;
          state_d     = SProp;
        end
      end
      SProp: begin
        state_d = SInc;
      end
      SInc: begin
        sum_d   = err_q[pca_pkg::DataW-1] ? -term48 : term48;
        state_d = SClamp;
      end
      SClamp: begin
        if (acc > lim_ext) begin
          isum_d = lim_ext[pca_pkg::DataW-1:0];
        end else if (acc < -lim_ext) begin
          isum_d = -lim_ext[pca_pkg::DataW-1:0];
        end else begin
          isum_d = acc[pca_pkg::DataW-1:0];
        end
        state_d = SInt;
      end
      SInt: begin
        q_d     = prod;
        state_d = SDstart;
      end
      SDstart: begin
        sum_d = isum_q[pca_pkg::DataW-1] ? (sum_q - term48) : (sum_q + term48);
        if (dt_q > pca_pkg::DtThreshold) begin
          div_start = 1'b1;
          state_d   = SDiv;
        end else begin
          state_d = SDone;
        end
      end
      SDiv: begin
        if (div_done) begin
          sum_d   = diff_q[pca_pkg::DiffW-1] ? (sum_q - quo_ext) : (sum_q + quo_ext);
          state_d = SDone;
        end
      end
      SDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Saturated drive value.
  always_comb begin
    if (sum_q > sat_hi) begin
      res_o = 32'h7FFF_FFFF;
    end else if (sum_q < sat_lo) begin
      res_o = 32'h8000_0000;
    end else begin
      res_o = sum_q[pca_pkg::DataW-1:0];
    end
  end

  assign in_ready_o = (state_q == SIdle);

  // Sequencer state and controller history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      last_err_q  <= '0;
      last_meas_q <= '0;
      isum_q      <= '0;
    end else begin
      state_q     <= state_d;
      last_err_q  <= last_err_d;
      last_meas_q <= last_meas_d;
      isum_q      <= isum_d;
    end
  end

  // Working registers of the current word.
  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    dt_q   <= dt_d;
    diff_q <= diff_d;
    sum_q  <= sum_d;
    q_q    <= q_d;
  end

endmodule

// ===== src/pid_controller_anti_windup.sv =====
// Top level of the fixed-point PID controller with a clamped integral.
`timescale 1ns / 1ps

// One input word (error, measurement, time step, derivative-mode flag) yields one
// saturated Q16.16 drive value. The block takes one word at a time: a word with
// a time step above 16 raw Q8.24 units passes through the bit-serial derivative
// divider (one quotient bit a cycle over 49 bits) before its result is ready.
// When the derivative quotient is capped the divider finishes at once, and a
// shorter time step skips the derivative. The four products (the three gains
// and the integral increment) share one registered multiplier. The result sits
// in an output register, so the next word is accepted while the previous result
// waits to be taken. Configuration writes are registered and should be made while
// the block is idle.

module pid_controller_anti_windup (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input word.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // error_value[31:0], measured_value[63:32], time_step[95:64]
  input  logic [0:0]  s_axis_tuser,   // deriv_on_measurement[0]
  // Result word.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // drive_value[31:0]
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);

  pca_pkg::cfg_t             cfg_q, cfg_d;
  logic                      out_valid_q, out_valid_d;
  logic [pca_pkg::DataW-1:0] out_data_q, out_data_d;
  logic                      res_valid;
  logic                      res_ready;
  logic [pca_pkg::DataW-1:0] res;

  // Register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pca_pkg::RegKp:    cfg_d.kp    = cfg_data_i;
        pca_pkg::RegKi:    cfg_d.ki    = cfg_data_i;
        pca_pkg::RegKd:    cfg_d.kd    = cfg_data_i;
        pca_pkg::RegLimit: cfg_d.limit = cfg_data_i;
        default:           cfg_d       = cfg_q;
      endcase
    end
  end

  pca_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .err_i       (s_axis_tdata[31:0]),
    .meas_i      (s_axis_tdata[63:32]),
    .dt_i        (s_axis_tdata[95:64]),
    .on_meas_i   (s_axis_tuser[0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: loads when empty or when its word is being taken.
  assign res_ready = ~out_valid_q | m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_data_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp    <= '0;
      cfg_q.ki    <= '0;
      cfg_q.kd    <= '0;
      cfg_q.limit <= {pca_pkg::GainW{1'b1}};
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== src/pca_checker.sv =====
// Port-level assertions for the PID controller, bound to the top level.
`timescale 1ns / 1ps

module pca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Once a word is taken the block is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in work");

  // A result never shows up right after its word is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

endmodule

bind pid_controller_anti_windup pca_checker u_pca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/pca_drive_checker.sv =====
// Checker for the PID controller: watches the channels, predicts each drive value and compares.
`timescale 1ns / 1ps

module pca_drive_checker
  import pca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [95:0]       in_data_i,    // error_value[31:0], measured_value[63:32], time_step[95:64]
  input  logic [0:0]        in_user_i,    // deriv_on_measurement[0]
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [31:0]       out_data_i,   // drive_value[31:0]
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [GainW-1:0]  cfg_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);

  localparam longint DriveMax = 64'sd2147483647;
  localparam longint DriveMin = -64'sd2147483648;
  localparam logic [71:0] DerivCap = 72'd1 << 48;

  // Gains and clamp as the block should hold them.
  logic [GainW-1:0] kp_q, ki_q, kd_q, limit_q;

  // Controller state.
  longint integral_q;
  longint last_err_q;
  longint last_meas_q;

  // Drive values still to come, oldest first.
  logic [DataW-1:0] drive_expect_q[$];
  logic [DataW-1:0] drive_want;

  // Truncates factor * x / 2^shift toward zero; the product never exceeds 63 bits.
  function automatic longint trunc_mul(input logic [31:0] factor, input longint x,
                                       input int shift);
    logic [63:0] mag_x;
    logic [63:0] prod;
    mag_x = (x < 0) ? 64'(-x) : 64'(x);
    prod  = (64'(factor) * mag_x) >> shift;
    return (x < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // Advances the controller by one word and returns the saturated drive value.
  function automatic logic [DataW-1:0] compute_drive(input logic signed [DataW-1:0] err,
                                                     input logic signed [DataW-1:0] meas,
                                                     input logic [DtW-1:0] dt,
                                                     input logic on_meas);
    longint p_term, i_term, d_term, acc, diff, total, lim;
    logic [63:0] diff_mag;
    logic [71:0] quo;
    p_term = trunc_mul(32'(kp_q), longint'(err), 16);

    // Integrate error * dt, then clamp symmetrically.
    lim = longint'(limit_q);
    acc = integral_q + trunc_mul(dt, longint'(err), 24);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    integral_q = acc;
    i_term = trunc_mul(32'(ki_q), integral_q, 16);

    // Derivative only above the one-microsecond threshold, capped at 2^48.
    d_term = 0;
    if (dt > DtThreshold) begin
      diff = on_meas ? (last_meas_q - longint'(meas)) : (longint'(err) - last_err_q);
      diff_mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      quo = (72'(64'(kd_q) * diff_mag) << 8) / 72'(dt);
      if (quo > DerivCap) quo = DerivCap;
      d_term = (diff < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    end

    last_err_q  = longint'(err);
    last_meas_q = longint'(meas);

    total = p_term + i_term + d_term;
    if (total > DriveMax) total = DriveMax;
    if (total < DriveMin) total = DriveMin;
    return total[DataW-1:0];
  endfunction

  // Prints one line for the first few mismatches and counts every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count_o < 30) begin
      $display("[%0t] drive mismatch: %s, got %h want %h (after %0d good words)",
               $realtime, what, got, want, checked_o);
    end
    fail_count_o++;
  endtask

  // Follow configuration writes, accepted words and accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        = '0;
      ki_q        = '0;
      kd_q        = '0;
      limit_q     = '1;
      integral_q  = 0;
      last_err_q  = 0;
      last_meas_q = 0;
      drive_expect_q.delete();
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegKp:    kp_q = cfg_data_i;
          RegKi:    ki_q = cfg_data_i;
          RegKd:    kd_q = cfg_data_i;
          RegLimit: limit_q = cfg_data_i;
          default: ;
        endcase
      end

      // Compare before queuing, so a fresh word can never hide a stray result.
      if (out_valid_i && out_ready_i) begin
        if (drive_expect_q.size() == 0) begin
          report_mismatch("word with nothing expected", out_data_i, '0);
        end else begin
          drive_want = drive_expect_q.pop_front();
          if (out_data_i !== drive_want) begin
            report_mismatch("wrong drive_value", out_data_i, drive_want);
          end
          checked_o++;
        end
      end

      if (in_valid_i && in_ready_i) begin
        drive_expect_q.push_back(compute_drive(in_data_i[31:0], in_data_i[63:32],
                                               in_data_i[95:64], in_user_i[0]));
      end
      pending_o = drive_expect_q.size();
    end
  end

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    pending_o    = 0;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top of the PID controller: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import pca_pkg::*;

  localparam int NumPhases     = 8;
  localparam int WordsPerPhase = 104;
  localparam int WatchdogLimit = 4000;
  localparam logic [GainW-1:0] GainMax = 31'h7FFF_FFFF;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              s_valid = 1'b0;
  logic              s_ready;
  logic [95:0]       s_data = '0;
  logic [0:0]        s_user = '0;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [31:0]       m_data;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = RegKp;
  logic [GainW-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int words_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int rx_cycle = 0;
  int plant_meas = 0;

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pid_controller_anti_windup i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  pca_drive_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_user_i    (s_user),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver: ready always, at random or sparsely, with a recurring long hold-off.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready  <= 1'b0;
      rx_cycle <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if ((rx_cycle % 6000) >= 1000 && (rx_cycle % 6000) < 1700) begin
        m_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 1500) % 3)
          0:       m_ready <= 1'b1;
          1:       m_ready <= 1'($urandom_range(0, 1));
          default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("Timeout: no word moved for %0d cycles", WatchdogLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Writes one register; the enable is high for exactly one edge.
  task automatic write_reg(input logic [1:0] idx, input logic [GainW-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_gains(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
                           input logic [GainW-1:0] kd, input logic [GainW-1:0] limit);
    write_reg(RegKp, kp);
    write_reg(RegKi, ki);
    write_reg(RegKd, kd);
    write_reg(RegLimit, limit);
    settings_used++;
  endtask

  // Stops offering and waits until every expected drive value has come back.
  task automatic drain();
    s_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // Offers one word in bursts with random gaps between them, and waits for its acceptance.
  task automatic send_word(input logic [31:0] err, input logic [31:0] meas,
                           input logic [31:0] dt, input logic on_meas);
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_valid <= 1'b1;
    s_data  <= {dt, meas, err};
    s_user  <= on_meas;
    do @(posedge clk); while (!s_ready);
    burst_left--;
    words_sent++;
  endtask

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GainMax;
      2:       return GainW'($urandom_range(0, 32'h0000_FFFF));
      3:       return GainW'($urandom());
      default: return GainW'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  function automatic logic [GainW-1:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return GainMax;
      2:       return GainW'($urandom());
      default: return GainW'($urandom_range(32'h0001_0000, 32'h0100_0000));
    endcase
  endfunction

  // Mostly a plant-like trace of small errors and a drifting measurement, some full-range noise.
  task automatic send_random_word();
    int err;
    int meas;
    logic [31:0] dt;
    case ($urandom_range(0, 9))
      0:       err = int'($urandom());
      1:       err = ($urandom_range(0, 1) == 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: err = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      meas = int'($urandom());
    end else begin
      meas = plant_meas + int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    end
    plant_meas = meas;
    case ($urandom_range(0, 9))
      0:       dt = $urandom_range(0, 16);
      1:       dt = $urandom_range(17, 64);
      2:       dt = $urandom();
      default: dt = $urandom_range(32'h0000_4000, 32'h0010_0000);
    endcase
    send_word(err, meas, dt, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Moderate gains with a clamp of 100: full-scale words, zero and threshold time steps.
    set_gains(31'h0001_0000, 31'h0000_8000, 31'h0000_4000, 31'h0064_0000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0001_0000, 32'h0000_1000, 32'd16, 1'b0);
    send_word(32'h0002_0000, 32'h0000_2000, 32'd17, 1'b0);
    send_word(32'h0002_0000, 32'hFFFF_0000, 32'd17, 1'b1);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_word(32'hFFFF_0000, 32'h0003_0000, 32'h0001_0000, 1'b1);
    send_word(32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 1'b0);
    drain();

    // Largest gains: saturation both ways and a capped derivative.
    set_gains(GainMax, GainMax, GainMax, GainMax);
    send_word(32'h7FFF_FFFF, 32'h0000_0000, 32'd17, 1'b0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'd17, 1'b1);
    send_word(32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    drain();

    // Zero clamp holds the integral at zero.
    set_gains('0, GainMax, '0, '0);
    send_word(32'h7FFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 32'hEDCB_A987, 32'h0100_0000, 1'b1);
    send_word(32'h0001_0000, 32'h0000_0000, 32'd0, 1'b0);

    // Random phases, the first two at the extremes of the settings.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0:       set_gains(GainMax, GainMax, GainMax, GainMax);
        1:       set_gains('0, '0, '0, '0);
        default: set_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit());
      endcase
      repeat (WordsPerPhase) send_random_word();
    end

    drain();
    repeat (64) @(posedge clk);

    $display("Sent %0d words under %0d gain settings; %0d drive values compared, %0d wrong.",
             words_sent, settings_used, checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pca_pkg.sv
src/pca_mul.sv
src/pca_div.sv
src/pca_core.sv
src/pid_controller_anti_windup.sv
src/pca_checker.sv
verif/pca_drive_checker.sv
verif/tb_top.sv
